FILE: hdl/scpg_pkg.sv
// ----------------------------------------------------------------------------
// scpg_pkg
// Shared types, widths and codes for the sync clock pulse generator.
// ----------------------------------------------------------------------------
package scpg_pkg;

	// Internal counter width (period, airwheel and record tick counters)
	localparam int unsigned CNT_W = 32;
	// Register and result word width
	localparam int unsigned WORD_W = 32;
	// Compare width: wide enough for both a counter and a register word
	localparam int unsigned CMP_W = (CNT_W > WORD_W) ? CNT_W : WORD_W;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [CMP_W-1:0]     cmp_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [2:0] {
		REQ_CLK_TICK    = 3'd0,
		REQ_SAMPLE_TICK = 3'd1,
		REQ_REC_LEVEL   = 3'd2,
		REQ_RST_PERIOD  = 3'd3,
		REQ_RST_REC     = 3'd4,
		REQ_ARM_PULSE   = 3'd5
	} req_e;

	localparam cfg_idx_t CFG_CLOCK_ENABLE    = 2'd0;
	localparam cfg_idx_t CFG_CLOCK_PERIOD    = 2'd1;
	localparam cfg_idx_t CFG_AIRWHEEL_PERIOD = 2'd2;

	typedef struct packed {
		logic [2:0] req_type;
		logic       run_active;
		logic       tap_tempo_set;
		logic       record_external_sync;
		logic       airwheel_active;
		logic       record_level;
	} req_item_t;

	typedef struct packed {
		logic  sync_out;
		logic  clock_edge;
		logic  led_blink;
		word_t rec_count;
		word_t last_rec_count;
	} rsp_item_t;

	typedef struct packed {
		logic  clock_enable;
		word_t clock_period;
		word_t airwheel_period;
	} cfg_t;

	// Counter to result word: extend or truncate to 32 bits
	function automatic word_t cnt_to_word(cnt_t x);
		cmp_t w;
		w = cmp_t'(x);
		return w[WORD_W-1:0];
	endfunction

endpackage

FILE: hdl/scpg_if.sv
// ----------------------------------------------------------------------------
// scpg interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface scpg_req_if;
	logic                 valid;
	logic                 ready;
	scpg_pkg::req_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface scpg_rsp_if;
	logic                 valid;
	logic                 ready;
	scpg_pkg::rsp_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface scpg_cfg_if;
	logic                 valid;
	logic                 ready;
	scpg_pkg::cfg_idx_t   index;
	scpg_pkg::word_t      data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sync_clock_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// sync_clock_pulse_generator_unit
// A request beat passes through the input register and then the result register before result valid.
// Throughput: one request beat per cycle while the result side is not stalled; the core state updates in one pass.
// A waiting result does not block intake while the input register is free.
// Reset (arst_n low, async): counters, pulse flag and sync level cleared,
// clock_enable set, both period registers cleared, both stages emptied.
// ----------------------------------------------------------------------------
module sync_clock_pulse_generator_unit (
	input  logic      clk,
	input  logic      arst_n,
	scpg_req_if.sink  req,
	scpg_rsp_if.source rsp,
	scpg_cfg_if.sink  cfg
);

	scpg_pkg::cfg_t      regs;
	scpg_pkg::req_item_t item_s1;
	logic                vld_s1;
	scpg_pkg::rsp_item_t rsp_d;
	scpg_pkg::rsp_item_t rsp_s2;
	logic                vld_s2;
	logic                adv;
	logic                fire;

	// Register file; the user must write it only while the datapath is idle (not enforced here)
	scpg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Result register can load when empty or being drained this cycle
	assign adv  = !vld_s2 || rsp.ready;
	// Request in stage 1 is applied to the state as it moves to stage 2
	assign fire = vld_s1 && adv;
	// Stage 1 frees up whenever it is empty or moving on
	assign req.ready = !vld_s1 || adv;

	scpg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.regs   (regs),
		.rsp    (rsp_d)
	);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (fire) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

endmodule

FILE: hdl/scpg_cfg.sv
// ----------------------------------------------------------------------------
// scpg_cfg
// Configuration register file; writes always taken.
// ----------------------------------------------------------------------------
module scpg_cfg (
	input  logic             clk,
	input  logic             arst_n,
	scpg_cfg_if.sink         cfg,
	output scpg_pkg::cfg_t   regs
);

	scpg_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.clock_enable    <= 1'b1;
			regs_q.clock_period    <= '0;
			regs_q.airwheel_period <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				scpg_pkg::CFG_CLOCK_ENABLE:    regs_q.clock_enable    <= cfg.data[0];
				scpg_pkg::CFG_CLOCK_PERIOD:    regs_q.clock_period    <= cfg.data;
				scpg_pkg::CFG_AIRWHEEL_PERIOD: regs_q.airwheel_period <= cfg.data;
				default: ; // unmapped index: ignored
			endcase
		end
	end

endmodule

FILE: hdl/scpg_core.sv
// ----------------------------------------------------------------------------
// scpg_core
// Counter and pulse state; one request applied per fire strobe.
// ----------------------------------------------------------------------------
module scpg_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  scpg_pkg::req_item_t  item,
	input  scpg_pkg::cfg_t       regs,
	output scpg_pkg::rsp_item_t  rsp
);

	scpg_pkg::cnt_t period_cnt_q, air_cnt_q, rec_ticks_q, cap_ticks_q;
	logic           pending_q, sync_q;

	scpg_pkg::cnt_t period_cnt_d, air_cnt_d, rec_ticks_d, cap_ticks_d;
	logic           pending_d, sync_d, edge_d, blink_d;
	scpg_pkg::cmp_t pc_w, ac_w, per_w, aper_w;

	always_comb begin
		pc_w   = scpg_pkg::cmp_t'(period_cnt_q);
		ac_w   = scpg_pkg::cmp_t'(air_cnt_q);
		per_w  = scpg_pkg::cmp_t'(regs.clock_period);
		aper_w = scpg_pkg::cmp_t'(regs.airwheel_period);

		period_cnt_d = period_cnt_q;
		air_cnt_d    = air_cnt_q;
		rec_ticks_d  = rec_ticks_q;
		cap_ticks_d  = cap_ticks_q;
		pending_d    = pending_q;
		sync_d       = sync_q;
		edge_d       = 1'b0;
		blink_d      = 1'b0;

		case (item.req_type)
			scpg_pkg::REQ_CLK_TICK: begin
				if (regs.clock_enable && (item.run_active || item.tap_tempo_set)) begin
					if (!item.record_external_sync || item.tap_tempo_set) begin
						period_cnt_d = period_cnt_q + 1'b1;
						if (pc_w >= per_w) begin
							edge_d       = 1'b1;
							period_cnt_d = '0;
						end
					end else if (item.airwheel_active) begin
						period_cnt_d = period_cnt_q + 1'b1;
						if (pc_w < per_w) begin
							// inserted-clock path
							air_cnt_d = air_cnt_q + 1'b1;
							if (ac_w >= aper_w) begin
								blink_d   = 1'b1;
								edge_d    = 1'b1;
								air_cnt_d = '0;
							end
						end else begin
							// period end: pulse only if no insertion configured
							if (per_w <= aper_w) begin
								edge_d    = 1'b1;
								air_cnt_d = '0;
							end
							period_cnt_d = '0;
						end
					end
					rec_ticks_d = rec_ticks_q + 1'b1;
				end
				if (edge_d) begin
					sync_d    = 1'b1;
					pending_d = 1'b1;
				end
			end
			scpg_pkg::REQ_SAMPLE_TICK: begin
				if (pending_q) begin
					pending_d = 1'b0;
					sync_d    = 1'b0;
				end
			end
			scpg_pkg::REQ_REC_LEVEL: begin
				if (!item.record_level) begin
					cap_ticks_d = rec_ticks_q;
					rec_ticks_d = '0;
				end
			end
			scpg_pkg::REQ_RST_PERIOD: period_cnt_d = '0;
			scpg_pkg::REQ_RST_REC:    rec_ticks_d  = '0;
			scpg_pkg::REQ_ARM_PULSE:  pending_d    = 1'b1;
			default: ; // unused codes: no change
		endcase

		rsp.sync_out       = sync_d;
		rsp.clock_edge     = edge_d;
		rsp.led_blink      = blink_d;
		rsp.rec_count      = scpg_pkg::cnt_to_word(rec_ticks_d);
		rsp.last_rec_count = scpg_pkg::cnt_to_word(cap_ticks_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cnt_q <= '0;
			air_cnt_q    <= '0;
			rec_ticks_q  <= '0;
			cap_ticks_q  <= '0;
			pending_q    <= 1'b0;
			sync_q       <= 1'b0;
		end else if (fire) begin
			period_cnt_q <= period_cnt_d;
			air_cnt_q    <= air_cnt_d;
			rec_ticks_q  <= rec_ticks_d;
			cap_ticks_q  <= cap_ticks_d;
			pending_q    <= pending_d;
			sync_q       <= sync_d;
		end
	end

endmodule

FILE: tb/sv/pulse_tracker_pkg.sv
// ----------------------------------------------------------------------------
// pulse_tracker_pkg
// Scoreboard for the sync clock pulse generator. Keeps its own copy of the
// registers and counters, predicts the status beat for every accepted request
// and compares returned status beats against the oldest prediction.
// ----------------------------------------------------------------------------
package pulse_tracker_pkg;
	import scpg_pkg::*;

	class pulse_tracker;
		// register copies
		logic  enable;
		word_t period;
		word_t air_period;
		// counter and flag copies
		cnt_t  period_cnt;
		cnt_t  air_cnt;
		cnt_t  rec_ticks;
		cnt_t  captured;
		logic  pending;
		logic  sync;

		rsp_item_t sync_status_q[$];
		int        errors;

		function new();
			enable     = 1'b1;
			period     = '0;
			air_period = '0;
			period_cnt = '0;
			air_cnt    = '0;
			rec_ticks  = '0;
			captured   = '0;
			pending    = 1'b0;
			sync       = 1'b0;
			errors     = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void apply_write(cfg_idx_t idx, word_t val);
			case (idx)
				CFG_CLOCK_ENABLE:    enable = val[0];
				CFG_CLOCK_PERIOD:    period = val;
				CFG_AIRWHEEL_PERIOD: air_period = val;
				default: ;
			endcase
		endfunction

		// advance the counters for one request and queue the status it yields
		function void note_request(req_item_t r);
			rsp_item_t st;
			cnt_t      prev;
			cnt_t      aprev;
			logic      fired;
			logic      inserted;
			fired    = 1'b0;
			inserted = 1'b0;
			case (r.req_type)
				REQ_CLK_TICK: begin
					if (enable && (r.run_active || r.tap_tempo_set)) begin
						prev = period_cnt;
						if (!r.record_external_sync || r.tap_tempo_set) begin
							period_cnt = prev + 1'b1;
							if (cmp_t'(prev) >= cmp_t'(period)) begin
								fired      = 1'b1;
								period_cnt = '0;
							end
						end else if (r.airwheel_active) begin
							period_cnt = prev + 1'b1;
							if (cmp_t'(prev) < cmp_t'(period)) begin
								aprev   = air_cnt;
								air_cnt = aprev + 1'b1;
								if (cmp_t'(aprev) >= cmp_t'(air_period)) begin
									fired    = 1'b1;
									inserted = 1'b1;
									air_cnt  = '0;
								end
							end else begin
								// period end: pulse only when no insertion fits
								if (period <= air_period) begin
									fired   = 1'b1;
									air_cnt = '0;
								end
								period_cnt = '0;
							end
						end
						rec_ticks = rec_ticks + 1'b1;
					end
				end
				REQ_SAMPLE_TICK: begin
					if (pending) begin
						pending = 1'b0;
						sync    = 1'b0;
					end
				end
				REQ_REC_LEVEL: begin
					if (!r.record_level) begin
						captured  = rec_ticks;
						rec_ticks = '0;
					end
				end
				REQ_RST_PERIOD: period_cnt = '0;
				REQ_RST_REC:    rec_ticks = '0;
				REQ_ARM_PULSE:  pending = 1'b1;
				default: ;
			endcase
			if (fired) begin
				sync    = 1'b1;
				pending = 1'b1;
			end
			st.sync_out       = sync;
			st.clock_edge     = fired;
			st.led_blink      = inserted;
			st.rec_count      = word_t'(rec_ticks);
			st.last_rec_count = word_t'(captured);
			sync_status_q.push_back(st);
		endfunction

		task compare_field(string name, word_t got, word_t want);
			if (got !== want)
				report($sformatf("%s got %0h, expected %0h", name, got, want));
		endtask

		task check_status(rsp_item_t got);
			rsp_item_t want;
			if (sync_status_q.size() == 0) begin
				report("status beat with no request outstanding");
				return;
			end
			want = sync_status_q.pop_front();
			compare_field("sync_out", word_t'(got.sync_out), word_t'(want.sync_out));
			compare_field("clock_edge", word_t'(got.clock_edge), word_t'(want.clock_edge));
			compare_field("led_blink", word_t'(got.led_blink), word_t'(want.led_blink));
			compare_field("rec_count", got.rec_count, want.rec_count);
			compare_field("last_rec_count", got.last_rec_count, want.last_rec_count);
		endtask
	endclass

endpackage

FILE: tb/sv/tb_sync_clock_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_sync_clock_pulse_generator_unit
// Drives request beats into the sync clock pulse generator, a directed set
// first and then random phases under several register settings, with random
// gaps on the request side and random stalls on the status side. Every status
// beat is checked field by field against the tracker's prediction.
// ----------------------------------------------------------------------------
module tb_sync_clock_pulse_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import scpg_pkg::*;
	import pulse_tracker_pkg::*;

	// request codes the block leaves alone
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;

	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 86;
	localparam int SETTLE      = 4;   // a little over the request-to-result path (input reg, result reg)

	logic clk;
	logic arst_n;

	scpg_req_if req_ch ();
	scpg_rsp_if rsp_ch ();
	scpg_cfg_if cfg_ch ();

	sync_clock_pulse_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	pulse_tracker tracker = new();

	// calm flags give stretches of back-to-back beats on either side
	bit req_calm;
	bit rsp_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the slowest correct run is roughly 1100 beats, each with its longest
	// request gap and status stall; this limit is well above that.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic req_item_t make_req(logic [2:0] kind, logic run, logic tap,
		logic ext, logic air, logic lvl);
		req_item_t r;
		r.req_type             = kind;
		r.run_active           = run;
		r.tap_tempo_set        = tap;
		r.record_external_sync = ext;
		r.airwheel_active      = air;
		r.record_level         = lvl;
		return r;
	endfunction

	// Mostly clock ticks and sample ticks so that pulses actually fire and get
	// cleared; the rest is record edges, counter resets, arming and spare codes.
	function automatic req_item_t rand_req();
		int          w;
		logic [2:0]  kind;
		w = $urandom_range(0, 99);
		if (w < 50)
			kind = REQ_CLK_TICK;
		else if (w < 68)
			kind = REQ_SAMPLE_TICK;
		else if (w < 78)
			kind = REQ_REC_LEVEL;
		else if (w < 82)
			kind = REQ_RST_PERIOD;
		else if (w < 86)
			kind = REQ_RST_REC;
		else if (w < 93)
			kind = REQ_ARM_PULSE;
		else
			kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
		return make_req(kind, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
			1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
			1'($urandom_range(0, 1)));
	endfunction

	// Called at a rising edge; returns at the edge where the beat was taken.
	// valid is only lowered when a gap is drawn, so it never toggles in one step.
	task automatic send_req(req_item_t item);
		int gap;
		if ($urandom_range(0, 15) == 0)
			req_calm = !req_calm;
		gap = req_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(item);
	endtask

	// Register write; the caller drops cfg valid after the last one.
	task automatic write_reg(cfg_idx_t idx, word_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.apply_write(idx, val);
	endtask

	// Stop sending and wait until every predicted status beat came back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (tracker.sync_status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Status side: random stalls, one check per accepted beat.
	initial begin
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rsp_calm = !rsp_calm;
			gap = rsp_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			tracker.check_status(rsp_ch.data);
		end
	end

	initial begin
		req_item_t directed[$];
		logic      en;
		word_t     cp;
		word_t     ap;

		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_CLOCK_ENABLE;
		cfg_ch.data  <= '0;
		arst_n       <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings (enabled, both periods zero).
		directed.push_back(make_req(REQ_SAMPLE_TICK, 0, 0, 0, 0, 0)); // nothing pending
		directed.push_back(make_req(REQ_ARM_PULSE,   0, 0, 0, 0, 0)); // armed, sync stays low
		directed.push_back(make_req(REQ_SAMPLE_TICK, 1, 1, 1, 1, 1)); // clears the armed flag
		directed.push_back(make_req(REQ_CLK_TICK,    0, 0, 1, 1, 1)); // neither run nor tap
		directed.push_back(make_req(REQ_CLK_TICK,    1, 0, 0, 0, 0)); // plain period pulse
		directed.push_back(make_req(REQ_SAMPLE_TICK, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_CLK_TICK,    0, 1, 1, 0, 0)); // tap overrides ext sync
		directed.push_back(make_req(REQ_CLK_TICK,    1, 0, 1, 0, 0)); // ext, no airwheel
		directed.push_back(make_req(REQ_CLK_TICK,    1, 0, 1, 1, 0)); // airwheel period end
		directed.push_back(make_req(REQ_CLK_TICK,    1, 0, 1, 1, 1));
		directed.push_back(make_req(REQ_REC_LEVEL,   0, 0, 0, 0, 1)); // rising record edge
		directed.push_back(make_req(REQ_REC_LEVEL,   1, 1, 1, 1, 0)); // falling: capture
		directed.push_back(make_req(REQ_CLK_TICK,    1, 1, 1, 1, 1));
		directed.push_back(make_req(REQ_CLK_TICK,    1, 1, 0, 0, 0));
		directed.push_back(make_req(REQ_RST_PERIOD,  1, 1, 1, 1, 1));
		directed.push_back(make_req(REQ_RST_REC,     0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_SPARE_A,     1, 1, 1, 1, 1)); // unused code
		directed.push_back(make_req(REQ_SPARE_B,     0, 0, 0, 0, 0)); // unused code
		directed.push_back(make_req(REQ_SAMPLE_TICK, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_REC_LEVEL,   0, 0, 0, 0, 0)); // capture of zero
		foreach (directed[i])
			send_req(directed[i]);
		drain();

		// Random phases. Registers only change once the block has drained.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin en = 1'b1; cp = 32'd3;          ap = 32'd1;          end
				1: begin en = 1'b1; cp = 32'd5;          ap = 32'd8;          end
				2: begin en = 1'b0; cp = 32'd2;          ap = 32'd2;          end
				3: begin en = 1'b1; cp = 32'd0;          ap = 32'd0;          end
				4: begin en = 1'b1; cp = 32'hFFFF_FFFF;  ap = 32'hFFFF_FFFF;  end
				5: begin en = 1'b1; cp = 32'd1;          ap = 32'hFFFF_FFFF;  end
				// clock period is large here; inserted pulses on every airwheel-path tick
				6: begin en = 1'b1; cp = 32'hFFFF_FFFF;  ap = 32'd0;          end
				7: begin en = 1'b1; cp = 32'd10;         ap = 32'd3;          end
				default: begin
					en = $urandom_range(0, 3) != 0;
					cp = $urandom_range(0, 12);
					ap = $urandom_range(0, 12);
				end
			endcase
			write_reg(CFG_CLOCK_ENABLE, word_t'(en));
			write_reg(CFG_CLOCK_PERIOD, cp);
			write_reg(CFG_AIRWHEEL_PERIOD, ap);
			cfg_ch.valid <= 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_req(rand_req());
			drain();
		end

		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
